// ===== hw/rtl/hqa_pkg.sv =====
// Shared constants, widths and control/status structs for the helicity
// quartet asymmetry core. No dependencies.
`default_nettype none

package hqa_pkg;

  // Field widths
  localparam int SCALER_W   = 32;
  localparam int ADC_W      = 12;
  localparam int GLEN_W     = 3;
  localparam int ASYM_W     = 16;
  localparam int ASYM_FRAC  = 14;

  // Arithmetic sizing
  localparam int FRAC_BITS  = 16;
  localparam int SUM_WIDTH  = 48;

  // Yield dividend: |dcoinc - daccid| scaled by 2^FRAC_BITS
  localparam int YNUM_W     = SCALER_W + FRAC_BITS;
  // Group dividend: |num_sum| scaled by 2^ASYM_FRAC
  localparam int GNUM_W     = SUM_WIDTH + ASYM_FRAC;
  // Shared divider sizing
  localparam int DIV_NW     = (YNUM_W > GNUM_W) ? YNUM_W : GNUM_W;
  localparam int DIV_DW     = (SCALER_W > SUM_WIDTH) ? SCALER_W : SUM_WIDTH;
  localparam int DIV_CW     = $clog2(DIV_NW + 1);
  // Width for the yield clip compare
  localparam int YCMP_W     = (YNUM_W > SUM_WIDTH) ? YNUM_W : SUM_WIDTH;

  localparam logic [DIV_CW-1:0] YIELD_ITERS = DIV_CW'(YNUM_W);
  localparam logic [DIV_CW-1:0] GROUP_ITERS = DIV_CW'(GNUM_W);

  localparam logic [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
  localparam logic [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

  localparam int ASYM_POS_LIMIT = 2**(ASYM_W-1) - 1;
  localparam int ASYM_NEG_LIMIT = 2**(ASYM_W-1);

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_THRESHOLD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_GROUP_LEN = CFG_IDX_W'(1);

  localparam logic [ADC_W-1:0]  THRESHOLD_RESET = ADC_W'(150);
  localparam logic [GLEN_W-1:0] GROUP_LEN_RESET = GLEN_W'(4);

  // Controller -> datapath
  typedef struct packed {
    logic capture;  // input transaction: latch differences, update history
    logic err_set;  // zero charge difference
    logic yload;    // start yield division
    logic yacc;     // accumulate yield into sums
    logic gload;    // start group ratio division
    logic emit;     // write result register, clear group state
  } hqa_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic skip;        // incoming event only primes / has no coincidence change
    logic dq_zero;     // captured charge difference is zero
    logic group_hit;   // captured event completes a group
    logic denom_zero;  // denominator sum is zero
    logic div_busy;    // shared divider iterating
  } hqa_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/hqa_in_if.sv =====
// Input event channel: valid/ready plus scaler, ADC and start-bit payload.
// Uses widths from hqa_pkg.
`default_nettype none

interface hqa_in_if;
  logic                          valid;
  logic                          ready;
  logic [hqa_pkg::SCALER_W-1:0]  coinc_count;
  logic [hqa_pkg::SCALER_W-1:0]  accid_count;
  logic [hqa_pkg::SCALER_W-1:0]  charge_count;
  logic [hqa_pkg::ADC_W-1:0]     helicity_adc;
  logic                          start_bit;

  modport source (
    output valid, coinc_count, accid_count, charge_count, helicity_adc, start_bit,
    input  ready
  );
  modport sink (
    input  valid, coinc_count, accid_count, charge_count, helicity_adc, start_bit,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/hqa_out_if.sv =====
// Result channel: valid/ready plus asymmetry and flag payload.
// Uses widths from hqa_pkg.
`default_nettype none

interface hqa_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [hqa_pkg::ASYM_W-1:0] asymmetry;
  logic                              div_error;
  logic                              saturated;

  modport source (
    output valid, asymmetry, div_error, saturated,
    input  ready
  );
  modport sink (
    input  valid, asymmetry, div_error, saturated,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/hqa_div.sv =====
// Shared restoring divider, one quotient bit per cycle, left-aligned dividend.
// Depends on hqa_pkg for sizing.
`default_nettype none

module hqa_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [hqa_pkg::DIV_NW-1:0]   dividend_i,
  input  wire logic [hqa_pkg::DIV_DW-1:0]   divisor_i,
  input  wire logic [hqa_pkg::DIV_CW-1:0]   iters_i,
  output logic                              busy_o,
  output logic [hqa_pkg::DIV_NW-1:0]        quotient_o
);

  localparam int NW = hqa_pkg::DIV_NW;
  localparam int DW = hqa_pkg::DIV_DW;
  localparam int CW = hqa_pkg::DIV_CW;

  logic [NW-1:0] num_q, num_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] dvs_q, dvs_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;

  logic [DW:0]   rem_sh;
  logic [DW:0]   trial;
  logic          take;

  always_comb begin
    rem_sh = {rem_q, num_q[NW-1]};
    trial  = rem_sh - {1'b0, dvs_q};
    take   = ~trial[DW];

    num_d  = num_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;

    if (start_i) begin
      num_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = iters_i;
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[NW-2:0], take};
      rem_d = take ? trial[DW-1:0] : rem_sh[DW-1:0];
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = num_q;

endmodule

`default_nettype wire

// ===== hw/rtl/hqa_datapath.sv =====
// Datapath: scaler history, yield and group sums, config registers, result register.
// Depends on hqa_pkg and hqa_div.
`default_nettype none

module hqa_datapath (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire hqa_pkg::hqa_cmd_t                   cmd_i,
  output hqa_pkg::hqa_sts_t                        sts_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [hqa_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [hqa_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  wire logic [hqa_pkg::SCALER_W-1:0]        coinc_i,
  input  wire logic [hqa_pkg::SCALER_W-1:0]        accid_i,
  input  wire logic [hqa_pkg::SCALER_W-1:0]        charge_i,
  input  wire logic [hqa_pkg::ADC_W-1:0]           adc_i,
  input  wire logic                                start_i,
  output logic signed [hqa_pkg::ASYM_W-1:0]        asym_o,
  output logic                                     div_error_o,
  output logic                                     saturated_o
);

  localparam int SW = hqa_pkg::SUM_WIDTH;
  localparam int XW = hqa_pkg::SCALER_W;
  localparam int GW = hqa_pkg::GLEN_W;
  localparam int AW = hqa_pkg::ASYM_W;
  localparam int NW = hqa_pkg::DIV_NW;
  localparam int DW = hqa_pkg::DIV_DW;
  localparam int CW = hqa_pkg::DIV_CW;
  localparam int YW = hqa_pkg::YNUM_W;
  localparam int QW = hqa_pkg::GNUM_W;
  localparam int MW = hqa_pkg::YCMP_W;

  function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] a, input logic [SW-1:0] b);
    logic [SW:0] s;
    s = {a[SW-1], a} + {b[SW-1], b};
    if (s[SW] != s[SW-1]) begin
      sat_add = s[SW] ? hqa_pkg::SUM_MIN : hqa_pkg::SUM_MAX;
    end else begin
      sat_add = s[SW-1:0];
    end
  endfunction

  // Config
  logic [hqa_pkg::ADC_W-1:0] thr_q;
  logic [GW-1:0]             glen_q;

  // History and group state
  logic [XW-1:0] prev_c_q, prev_a_q, prev_q_q;
  logic          primed_q;
  logic [GW-1:0] gc_q, gc_next;
  logic          hit_q;
  logic [SW-1:0] num_q, den_q;
  logic          sticky_q;

  // Per-event working registers
  logic [XW-1:0] dc_q, da_q, dq_q;
  logic          hel_q;
  logic          yneg_q;
  logic          gneg_q;

  // Result register
  logic [AW-1:0] asym_q;
  logic          err_q;
  logic          sat_q;

  // Divider hookup
  logic          div_start;
  logic [NW-1:0] div_dividend;
  logic [DW-1:0] div_divisor;
  logic [CW-1:0] div_iters;
  logic          div_busy;
  logic [NW-1:0] div_quo;

  // Yield prep
  logic [XW:0]   dd;
  logic [XW:0]   dd_abs;
  logic [XW-1:0] dq_abs;
  logic [NW-1:0] y_dividend;

  // Group prep
  logic [SW-1:0] num_abs, den_abs;
  logic [NW-1:0] g_dividend;

  // Yield accumulate
  logic [MW-1:0] qy_ext;
  logic [SW-1:0] ymag, yval, ynum;

  // Group result
  logic [QW-1:0] qg;
  logic [AW-1:0] asym_d;
  logic          sat_d;

  always_comb begin
    gc_next = start_i ? (gc_q + GW'(1)) : GW'(1);

    dd      = {dc_q[XW-1], dc_q} - {da_q[XW-1], da_q};
    dd_abs  = dd[XW] ? -dd : dd;
    dq_abs  = dq_q[XW-1] ? -dq_q : dq_q;
    y_dividend = NW'(dd_abs[XW-1:0]) << (NW - XW);

    num_abs = num_q[SW-1] ? -num_q : num_q;
    den_abs = den_q[SW-1] ? -den_q : den_q;
    g_dividend = NW'(num_abs) << (NW - SW);

    div_start    = cmd_i.yload | cmd_i.gload;
    div_dividend = cmd_i.gload ? g_dividend : y_dividend;
    div_divisor  = cmd_i.gload ? DW'(den_abs) : DW'(dq_abs);
    div_iters    = cmd_i.gload ? hqa_pkg::GROUP_ITERS : hqa_pkg::YIELD_ITERS;

    // Yield clipped to the sum range, signed, then gated by helicity
    qy_ext = MW'(div_quo[YW-1:0]);
    ymag   = (qy_ext > MW'(hqa_pkg::SUM_MAX)) ? hqa_pkg::SUM_MAX : qy_ext[SW-1:0];
    yval   = yneg_q ? -ymag : ymag;
    ynum   = hel_q ? yval : -yval;

    // Group ratio, saturated to Q2.14
    qg = div_quo[QW-1:0];
    if (!gneg_q && (qg > QW'(hqa_pkg::ASYM_POS_LIMIT))) begin
      asym_d = AW'(hqa_pkg::ASYM_POS_LIMIT);
      sat_d  = 1'b1;
    end else if (gneg_q && (qg > QW'(hqa_pkg::ASYM_NEG_LIMIT))) begin
      asym_d = {1'b1, {(AW-1){1'b0}}};
      sat_d  = 1'b1;
    end else begin
      asym_d = gneg_q ? -qg[AW-1:0] : qg[AW-1:0];
      sat_d  = 1'b0;
    end
  end

  hqa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .iters_i    (div_iters),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= hqa_pkg::THRESHOLD_RESET;
      glen_q   <= hqa_pkg::GROUP_LEN_RESET;
      prev_c_q <= '0;
      prev_a_q <= '0;
      prev_q_q <= '0;
      primed_q <= 1'b0;
      gc_q     <= '0;
      hit_q    <= 1'b0;
      num_q    <= '0;
      den_q    <= '0;
      sticky_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          hqa_pkg::CFG_IDX_THRESHOLD: thr_q  <= cfg_wdata_i[hqa_pkg::ADC_W-1:0];
          hqa_pkg::CFG_IDX_GROUP_LEN: glen_q <= cfg_wdata_i[GW-1:0];
          default: ;
        endcase
      end
      if (cmd_i.capture) begin
        prev_c_q <= coinc_i;
        prev_a_q <= accid_i;
        prev_q_q <= charge_i;
        primed_q <= 1'b1;
        if (!sts_o.skip) begin
          gc_q  <= gc_next;
          hit_q <= (gc_next == glen_q);
        end
      end
      if (cmd_i.err_set) begin
        sticky_q <= 1'b1;
      end
      if (cmd_i.yacc) begin
        num_q <= sat_add(num_q, ynum);
        den_q <= sat_add(den_q, yval);
      end
      if (cmd_i.emit) begin
        num_q    <= '0;
        den_q    <= '0;
        gc_q     <= '0;
        sticky_q <= 1'b0;
      end
    end
  end

  // Working and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      dc_q  <= coinc_i - prev_c_q;
      da_q  <= accid_i - prev_a_q;
      dq_q  <= charge_i - prev_q_q;
      hel_q <= (adc_i > thr_q);
    end
    if (cmd_i.yload) begin
      yneg_q <= dd[XW] ^ dq_q[XW-1];
    end
    if (cmd_i.gload) begin
      gneg_q <= num_q[SW-1] ^ den_q[SW-1];
    end
    if (cmd_i.emit) begin
      if (den_q == '0) begin
        asym_q <= '0;
        err_q  <= 1'b1;
        sat_q  <= 1'b0;
      end else begin
        asym_q <= asym_d;
        err_q  <= sticky_q;
        sat_q  <= sat_d;
      end
    end
  end

  always_comb begin
    sts_o.skip       = ~primed_q | (coinc_i == prev_c_q);
    sts_o.dq_zero    = (dq_q == '0);
    sts_o.group_hit  = hit_q;
    sts_o.denom_zero = (den_q == '0);
    sts_o.div_busy   = div_busy;
  end

  assign asym_o      = asym_q;
  assign div_error_o = err_q;
  assign saturated_o = sat_q;

endmodule

`default_nettype wire

// ===== hw/rtl/hqa_ctrl.sv =====
// Event sequencer: input handshake, divider sequencing, output valid.
// Depends on hqa_pkg.
`default_nettype none

module hqa_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              out_ready_i,
  output logic                   out_valid_o,
  input  wire hqa_pkg::hqa_sts_t sts_i,
  output hqa_pkg::hqa_cmd_t      cmd_o
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_PREP  = 7'b0000010,
    ST_YDIV  = 7'b0000100,
    ST_YACC  = 7'b0001000,
    ST_GPREP = 7'b0010000,
    ST_GDIV  = 7'b0100000,
    ST_EMIT  = 7'b1000000
  } hqa_state_e;

  hqa_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          if (!sts_i.skip) begin
            state_d = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        if (sts_i.dq_zero) begin
          cmd_o.err_set = 1'b1;
          state_d = sts_i.group_hit ? ST_GPREP : ST_IDLE;
        end else begin
          cmd_o.yload = 1'b1;
          state_d = ST_YDIV;
        end
      end
      ST_YDIV: begin
        if (!sts_i.div_busy) begin
          state_d = ST_YACC;
        end
      end
      ST_YACC: begin
        cmd_o.yacc = 1'b1;
        state_d = sts_i.group_hit ? ST_GPREP : ST_IDLE;
      end
      ST_GPREP: begin
        if (sts_i.denom_zero) begin
          state_d = ST_EMIT;
        end else begin
          cmd_o.gload = 1'b1;
          state_d = ST_GDIV;
        end
      end
      ST_GDIV: begin
        if (!sts_i.div_busy) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // wait for the result register to free up
        if (!out_valid_q || out_ready_i) begin
          cmd_o.emit = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== hw/rtl/helicity_quartet_asymmetry_core.sv =====
// Top level of the helicity quartet asymmetry core: controller, datapath, channels.
// Depends on hqa_pkg, hqa_in_if, hqa_out_if, hqa_ctrl, hqa_datapath.
//
// Usage:
//   in_ch carries one scaler event per transaction (valid & ready). out_ch
//   carries one group asymmetry result per completed group. The config port
//   (cfg_we_i, cfg_idx_i, cfg_wdata_i) writes helicity_threshold (index 0)
//   or group_length (index 1); write only while the core is idle.
// Sequencing:
//   An event that only primes the history, or has no coincidence change,
//   is finished at capture. A counted event steps through capture, prep,
//   the yield division (one quotient bit per cycle in the shared restoring
//   divider) and accumulate; a zero charge step skips the division and
//   sets the error flag instead. An event that closes a group then runs the
//   group ratio on the same divider, or goes straight to emit when the
//   denominator is zero.
//   The divider is the rate limiter; events are handled one at a time.
// Reset (rst_ni low, async): history, sums, group counter, error flag and
//   config registers return to their reset values; no result is pending.
// Stall: the result sits in the output register until taken; the next event
//   is accepted meanwhile. Only a second group result waits for the slot.
`default_nettype none

module helicity_quartet_asymmetry_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  hqa_in_if.sink                               in_ch,
  hqa_out_if.source                            out_ch,
  input  wire logic                            cfg_we_i,
  input  wire logic [hqa_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [hqa_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  hqa_pkg::hqa_cmd_t cmd;
  hqa_pkg::hqa_sts_t sts;

  logic in_ready;
  logic out_valid;

  // Sequencer
  hqa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ready),
    .out_ready_i (out_ch.ready),
    .out_valid_o (out_valid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Arithmetic, history and result register
  hqa_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .coinc_i     (in_ch.coinc_count),
    .accid_i     (in_ch.accid_count),
    .charge_i    (in_ch.charge_count),
    .adc_i       (in_ch.helicity_adc),
    .start_i     (in_ch.start_bit),
    .asym_o      (out_ch.asymmetry),
    .div_error_o (out_ch.div_error),
    .saturated_o (out_ch.saturated)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

  // No new event while the divider is still iterating
  a_ready_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready |-> !sts.div_busy)
    else $error("input ready while divider busy");

  // Divider is never restarted mid-operation
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.yload || cmd.gload) |-> !sts.div_busy)
    else $error("divider started while busy");

  // A new result only appears through an emit
  a_valid_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> $past(cmd.emit))
    else $error("output valid without emit");

  // Zero denominator gives a zero, flagged, unsaturated result
  a_zero_denom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit && sts.denom_zero) |=>
      (out_ch.asymmetry == '0) && out_ch.div_error && !out_ch.saturated)
    else $error("zero denominator result wrong");

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for helicity_quartet_asymmetry_core: drives scaler events,
// predicts each group asymmetry with a behavioral model and checks every result.
// Depends on hqa_pkg, hqa_in_if, hqa_out_if and the core RTL.

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hqa_pkg::*;

  localparam int CLK_HALF         = 5;
  localparam int RST_CYCLES       = 9;
  // Covers a closing event working through the core, with margin for an item in flight.
  localparam int SETTLE_CYCLES    = 200;
  localparam int RX_HOLD_CYCLES   = 1500;
  localparam int RAND_PHASE_ITEMS = 213;
  localparam int PRESSURE_ITEMS   = 25;
  localparam int CYCLE_LIMIT      = 1_500_000;

  localparam longint SUM_LIM = (longint'(1) <<< (SUM_WIDTH - 1)) - 1;

  typedef struct packed {
    logic [SCALER_W-1:0] coinc;
    logic [SCALER_W-1:0] accid;
    logic [SCALER_W-1:0] charge;
    logic [ADC_W-1:0]    adc;
    logic                start;
  } scaler_event_t;

  typedef struct packed {
    logic signed [ASYM_W-1:0] asym;
    logic                     div_error;
    logic                     saturated;
  } asym_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  hqa_in_if  in_ch ();
  hqa_out_if out_ch ();

  helicity_quartet_asymmetry_core u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Behavioral copy of the core state, advanced once per accepted transaction
  // ---------------------------------------------------------------------------
  logic [ADC_W-1:0]    thr_q       = THRESHOLD_RESET;
  logic [GLEN_W-1:0]   glen_q      = GROUP_LEN_RESET;
  logic [SCALER_W-1:0] last_coinc  = '0;
  logic [SCALER_W-1:0] last_accid  = '0;
  logic [SCALER_W-1:0] last_charge = '0;
  bit                  primed_q    = 1'b0;
  logic [GLEN_W-1:0]   grp_cnt     = '0;
  longint              num_acc     = 0;
  longint              den_acc     = 0;
  bit                  err_flag    = 1'b0;

  asym_result_t pending_asym[$];  // group results predicted but not yet seen

  // Stimulus/handshake controls
  bit tx_idle_en  = 1'b1;
  bit rx_stall_en = 1'b1;
  bit rx_hold_req = 1'b0;

  int unsigned err_cnt      = 0;
  int unsigned events_sent  = 0;
  int unsigned results_seen = 0;
  int unsigned sat_seen     = 0;
  int unsigned derr_seen    = 0;
  int unsigned cycle_cnt;

  // Signed add clamped to the SUM_WIDTH two's complement range
  function automatic longint sum_sat_add(longint a, longint b);
    longint lo;
    lo = -SUM_LIM - 1;
    if (b > 0 && a > SUM_LIM - b) return SUM_LIM;
    if (b < 0 && a < lo - b) return lo;
    return a + b;
  endfunction

  // Advance the model by one event; queue a group result when the group closes.
  function automatic void predict_asymmetry(scaler_event_t ev);
    int                dc, da, dq;
    longint            yield;
    longint unsigned   mag_num, mag_den, quo;
    bit                neg, was_primed;
    asym_result_t      res;
    // scaler differences wrap at 32 bits and read as signed
    dc = $signed(ev.coinc - last_coinc);
    da = $signed(ev.accid - last_accid);
    dq = $signed(ev.charge - last_charge);
    was_primed  = primed_q;
    last_coinc  = ev.coinc;
    last_accid  = ev.accid;
    last_charge = ev.charge;
    primed_q    = 1'b1;
    if (!was_primed || dc == 0) return;

    grp_cnt = grp_cnt + 1'b1;  // 3-bit wrap
    if (!ev.start) grp_cnt = GLEN_W'(1);

    if (dq == 0) begin
      err_flag = 1'b1;
    end else begin
      // Q.FRAC_BITS yield, truncated toward zero, then clipped to the sum range
      yield = ((longint'(dc) - longint'(da)) <<< FRAC_BITS) / longint'(dq);
      if (yield > SUM_LIM) yield = SUM_LIM;
      else if (yield < -SUM_LIM) yield = -SUM_LIM;
      num_acc = sum_sat_add(num_acc, (ev.adc > thr_q) ? yield : -yield);
      den_acc = sum_sat_add(den_acc, yield);
    end

    if (grp_cnt != glen_q) return;

    res = '0;
    res.div_error = err_flag || (den_acc == 0);
    if (den_acc != 0) begin
      mag_num = (num_acc < 0) ? -num_acc : num_acc;
      mag_den = (den_acc < 0) ? -den_acc : den_acc;
      neg     = (num_acc < 0) != (den_acc < 0);
      quo     = (mag_num << ASYM_FRAC) / mag_den;
      if (!neg && quo > ASYM_POS_LIMIT) begin
        quo = ASYM_POS_LIMIT;
        res.saturated = 1'b1;
      end else if (neg && quo > ASYM_NEG_LIMIT) begin
        quo = ASYM_NEG_LIMIT;
        res.saturated = 1'b1;
      end
      res.asym = ASYM_W'(neg ? -quo : quo);
    end
    pending_asym.push_back(res);
    num_acc  = 0;
    den_acc  = 0;
    grp_cnt  = '0;
    err_flag = 1'b0;
  endfunction

  // Build an event from scaler steps relative to the last accepted readings
  function automatic scaler_event_t next_event(logic [SCALER_W-1:0] dc, logic [SCALER_W-1:0] da,
                                               logic [SCALER_W-1:0] dq, logic [ADC_W-1:0] adc,
                                               logic start);
    scaler_event_t ev;
    ev.coinc  = last_coinc + dc;
    ev.accid  = last_accid + da;
    ev.charge = last_charge + dq;
    ev.adc    = adc;
    ev.start  = start;
    return ev;
  endfunction

  // Mostly plausible scaler steps, with skips, zero charge, clipping and jumps mixed in
  function automatic scaler_event_t rand_event();
    scaler_event_t       ev;
    int unsigned         kind;
    int                  t;
    logic [SCALER_W-1:0] dc, da, dq;
    logic [ADC_W-1:0]    adc;
    kind = $urandom_range(0, 99);
    dc   = $urandom_range(1, 5000);
    da   = $urandom_range(0, 3000);
    dq   = $urandom_range(1, 200000);
    if (kind < 10) begin
      dc = -dc;                        // coincidence scaler steps back
    end else if (kind < 18) begin
      dc = '0;                         // no coincidence change: not counted
    end else if (kind < 24) begin
      dq = '0;                         // charge stalled: error term
    end else if (kind < 30) begin
      dc = $urandom();                 // huge step over tiny charge: yield clips
      da = $urandom();
      dq = $urandom_range(1, 3);
    end else if (kind < 34) begin
      da = -da;
      dq = -dq;                        // charge going backwards
    end
    // helicity ADC either anywhere or right around the threshold
    if ($urandom_range(0, 1) == 0) begin
      adc = $urandom_range(0, 4095);
    end else begin
      t = int'(thr_q) + int'($urandom_range(0, 4)) - 2;
      if (t < 0) t = 0;
      if (t > 4095) t = 4095;
      adc = ADC_W'(t);
    end
    ev = next_event(dc, da, dq, adc, $urandom_range(0, 15) != 0);
    if (kind >= 95) begin
      ev.coinc  = $urandom();          // scaler jump to arbitrary readings
      ev.accid  = $urandom();
      ev.charge = $urandom();
    end
    return ev;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, watchdog, receiver and result check
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("%0t: run did not finish in %0d cycles, %0d results outstanding",
             $time, cycle_cnt, pending_asym.size());
    $display("== FAIL ==");
    $finish;
  end

  // out_ch.ready: random stall bursts, or one long hold-off when requested.
  // The hold-off is counted here so the sender keeps pushing in the meantime.
  initial begin : rx_ready_driver
    int unsigned run;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        run = RX_HOLD_CYCLES;
      end else if (rx_stall_en && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        run = $urandom_range(1, 19);
      end else begin
        out_ch.ready <= 1'b1;
        run = rx_stall_en ? $urandom_range(1, 30) : 1;
      end
      repeat (run - 1) @(negedge clk);
    end
  end

  // Each result transaction is matched against the oldest prediction
  always @(posedge clk) begin : result_check
    asym_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_asym.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result: expected none, got asym=%0d div_error=%0b sat=%0b",
                 $time, out_ch.asymmetry, out_ch.div_error, out_ch.saturated);
      end else begin
        want = pending_asym.pop_front();
        results_seen++;
        if (want.saturated) sat_seen++;
        if (want.div_error) derr_seen++;
        if (out_ch.asymmetry !== want.asym) begin
          err_cnt++;
          $display("%0t: asymmetry mismatch: expected %0d, got %0d",
                   $time, want.asym, out_ch.asymmetry);
        end
        if (out_ch.div_error !== want.div_error) begin
          err_cnt++;
          $display("%0t: div_error mismatch: expected %0b, got %0b",
                   $time, want.div_error, out_ch.div_error);
        end
        if (out_ch.saturated !== want.saturated) begin
          err_cnt++;
          $display("%0t: saturated mismatch: expected %0b, got %0b",
                   $time, want.saturated, out_ch.saturated);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Shared sender tasks
  // ---------------------------------------------------------------------------
  // One input transaction; the model advances at the accepting edge.
  task automatic send_event(input scaler_event_t ev);
    @(negedge clk);
    in_ch.valid        <= 1'b1;
    in_ch.coinc_count  <= ev.coinc;
    in_ch.accid_count  <= ev.accid;
    in_ch.charge_count <= ev.charge;
    in_ch.helicity_adc <= ev.adc;
    in_ch.start_bit    <= ev.start;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    events_sent++;
    predict_asymmetry(ev);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19) - 1) @(negedge clk);
    end
  endtask

  // Stop sending, wait for every predicted result, then let a trailing
  // non-result event finish inside the core.
  task automatic settle_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_asym.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    settle_idle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_IDX_THRESHOLD) thr_q = data[ADC_W-1:0];
    else glen_q = data[GLEN_W-1:0];
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset config (threshold 150, group 4): priming, wrap, skip, zero charge,
  // threshold boundary. The closing group carries the sticky error.
  task automatic test_reset_defaults();
    scaler_event_t ev;
    ev = '{coinc: '1, accid: '1, charge: '1, adc: 12'hFFF, start: 1'b1};
    send_event(ev);                                      // first event only primes
    send_event(next_event(5, 1, 2, 151, 1'b1));          // scalers wrap through zero
    send_event(next_event(0, 7, 9, 12'hABC, 1'b1));      // no coincidence change
    send_event(next_event(3, 1, 0, 4000, 1'b1));         // zero charge step
    send_event(next_event(40, 10, 300, 150, 1'b1));      // ADC equal to threshold: minus
    send_event(next_event(77, 5, 1000, 0, 1'b1));        // closes group of four
  endtask

  // All charge steps zero: empty denominator. A clear start bit mid-group
  // restarts the count without clearing the sums.
  task automatic test_zero_denominator();
    send_event(next_event(10, 2, 0, 200, 1'b1));
    send_event(next_event(11, 3, 0, 100, 1'b1));
    send_event(next_event(12, 4, 0, 300, 1'b0));         // count back to one
    send_event(next_event(13, 5, 0, 50, 1'b1));
    send_event(next_event(14, 6, 0, 250, 1'b1));
    send_event(next_event(15, 7, 0, 10, 1'b1));          // count four: emits
  endtask

  // Groups of two with a tiny denominator: clip high, clip low, then exact zero
  task automatic test_saturation();
    write_reg(CFG_IDX_GROUP_LEN, CFG_DATA_W'(2));
    send_event(next_event(1000, 0, 65536, 4095, 1'b1));
    send_event(next_event(-999, 0, 65536, 0, 1'b1));
    send_event(next_event(1000, 0, 65536, 0, 1'b1));
    send_event(next_event(-999, 0, 65536, 4095, 1'b1));
    send_event(next_event(700, 200, 3, 4095, 1'b1));
    send_event(next_event(700, 200, 3, 0, 1'b1));
  endtask

  // Full-scale scaler steps over unit charge: yields clip and the sums hit
  // both rails of the SUM_WIDTH range.
  task automatic test_sum_overflow();
    write_reg(CFG_IDX_GROUP_LEN, CFG_DATA_W'(3));
    send_event(next_event(32'h7FFF_FFFF, 32'h8000_0000, 1, 4095, 1'b1));
    send_event(next_event(32'h7FFF_FFFF, 32'h8000_0000, 1, 4095, 1'b1));
    send_event(next_event(32'h8000_0000, 32'h7FFF_FFFF, 1, 0, 1'b1));
    send_event(next_event(32'h8000_0000, 32'h7FFF_FFFF, 1, 4095, 1'b1));
    send_event(next_event(32'h8000_0000, 32'h7FFF_FFFF, 1, 4095, 1'b1));
    send_event(next_event(32'h8000_0000, 32'h7FFF_FFFF, 1, 4095, 1'b1));
  endtask

  // Every event closes a group while the receiver holds off: the result slot
  // fills and the core has to stall its input. Then drain completely.
  task automatic test_backpressure();
    write_reg(CFG_IDX_GROUP_LEN, CFG_DATA_W'(1));
    tx_idle_en  = 1'b0;
    rx_stall_en = 1'b0;
    rx_hold_req = 1'b1;
    repeat (PRESSURE_ITEMS)
      send_event(next_event($urandom_range(1, 5000), $urandom_range(0, 3000),
                            $urandom_range(1, 200000), $urandom_range(0, 4095), 1'b1));
    settle_idle();
    tx_idle_en  = 1'b1;
    rx_stall_en = 1'b1;
  endtask

  // Random traffic over a series of settings. Group lengths change between
  // phases without clearing the count, so a count left above the new length
  // has to wrap; length zero closes after eight events. Last phase runs flat out.
  task automatic test_random_phases();
    int unsigned      glen_order[8] = '{7, 2, 0, 1, 5, 3, 6, 4};
    int unsigned      p;
    logic [ADC_W-1:0] thr;
    for (p = 0; p < 8; p++) begin
      if (p == 0) thr = '0;
      else if (p == 1) thr = '1;
      else thr = $urandom_range(0, 4095);
      tx_idle_en  = (p != 7) && (p != 3);
      rx_stall_en = (p != 7) && (p != 4);
      write_reg(CFG_IDX_THRESHOLD, CFG_DATA_W'(thr));
      // upper data bits are don't-care for the group length register
      write_reg(CFG_IDX_GROUP_LEN,
                {9'($urandom_range(0, 511)), GLEN_W'(glen_order[p])});
      repeat (RAND_PHASE_ITEMS) send_event(rand_event());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = '0;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.coinc_count  = '0;
    in_ch.accid_count  = '0;
    in_ch.charge_count = '0;
    in_ch.helicity_adc = '0;
    in_ch.start_bit    = 1'b0;
    repeat (RST_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_zero_denominator();
    test_saturation();
    test_sum_overflow();
    test_backpressure();
    test_random_phases();
    settle_idle();

    $display("Run covered %0d scaler events and %0d group results (%0d clipped, %0d div_error),",
             events_sent, results_seen, sat_seen, derr_seen);
    $display("group lengths 0 to 7, thresholds 0 to 4095, long receiver hold-off with input stall");
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
